### rtl/vosd_pkg.sv
// shared constants, font table and types of the volume osd pixel overlay
package vosd_pkg;

  localparam int CoordW = 9;
  localparam int ColorW = 16;
  localparam int VolW   = 7;
  localparam int RelXW  = 9;
  localparam int RelYW  = 7;
  localparam int GlyphW = 4;

  localparam int FrameWidthDef  = 466;
  localparam int FrameHeightDef = 466;

  localparam int PanelW  = 280;
  localparam int PanelH  = 110;
  localparam int Scale   = 4;
  localparam int Pitch   = 24;
  localparam int TextTop = 18;
  localparam int BarX    = 24;
  localparam int BarY    = 72;
  localparam int BarW    = 232;
  localparam int BarH    = 18;
  localparam int VolMax  = 100;

  // fill = vol * BarW / 100 as a multiply by a reciprocal
  localparam int FillMul   = 1216376;
  localparam int FillShift = 19;
  localparam int ProdW     = 28;
  // tens digit of a two digit value
  localparam int TensMul   = 205;
  localparam int TensShift = 11;

  localparam int Left5  = (PanelW - (5 * Pitch - Scale)) / 2;
  localparam int Left6  = (PanelW - (6 * Pitch - Scale)) / 2;
  localparam int Left7  = (PanelW - (7 * Pitch - Scale)) / 2;
  localparam int Right5 = Left5 + 5 * Pitch - Scale;
  localparam int Right6 = Left6 + 6 * Pitch - Scale;
  localparam int Right7 = Left7 + 7 * Pitch - Scale;

  localparam logic [ColorW-1:0] ColorBlack = 16'h0000;
  localparam logic [ColorW-1:0] ColorWhite = 16'hFFFF;
  localparam logic [ColorW-1:0] ColorTrack = 16'h4208;

  localparam logic [GlyphW-1:0] GlyphZero  = 4'd0;
  localparam logic [GlyphW-1:0] GlyphOne   = 4'd1;
  localparam logic [GlyphW-1:0] GlyphV     = 4'd10;
  localparam logic [GlyphW-1:0] GlyphO     = 4'd11;
  localparam logic [GlyphW-1:0] GlyphL     = 4'd12;
  localparam logic [GlyphW-1:0] GlyphBlank = 4'd13;

  // 5x7 column font, bit 0 is the top row; unused codes are blank
  localparam logic [6:0] FontCols [16][5] = '{
    '{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E},
    '{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
    '{7'h42, 7'h61, 7'h51, 7'h49, 7'h46},
    '{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31},
    '{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10},
    '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
    '{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30},
    '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
    '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},
    '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E},
    '{7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F},
    '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E},
    '{7'h7F, 7'h40, 7'h40, 7'h40, 7'h40},
    '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
    '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
    '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00}
  };

  typedef struct packed {
    logic [7:0]        fill;
    logic [7:0]        text_left;
    logic [7:0]        text_right;
    logic [GlyphW-1:0] glyph4;
    logic [GlyphW-1:0] glyph5;
    logic [GlyphW-1:0] glyph6;
  } cfg_t;

endpackage

### rtl/vosd_cfg.sv
// volume register with the digit glyphs, text span and bar fill derived at write time
module vosd_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [vosd_pkg::VolW-1:0] cfg_wdata_i,
  output vosd_pkg::cfg_t            cfg_o
);

  logic [vosd_pkg::VolW-1:0]   vol;
  logic [vosd_pkg::ProdW-1:0]  fill_prod;
  logic [14:0]                 tens_prod;
  logic [vosd_pkg::GlyphW-1:0] tens;
  logic [vosd_pkg::VolW-1:0]   ones_w;
  logic [vosd_pkg::GlyphW-1:0] ones;
  vosd_pkg::cfg_t              cfg_d, cfg_q;

  always_comb begin
    vol = (cfg_wdata_i > vosd_pkg::VolW'(vosd_pkg::VolMax)) ?
          vosd_pkg::VolW'(vosd_pkg::VolMax) : cfg_wdata_i;
    fill_prod = vosd_pkg::ProdW'(vol) * vosd_pkg::ProdW'(vosd_pkg::FillMul);
    tens_prod = 15'(vol) * 15'(vosd_pkg::TensMul);
    tens      = tens_prod[vosd_pkg::TensShift +: vosd_pkg::GlyphW];
    ones_w    = vol - vosd_pkg::VolW'(tens) * vosd_pkg::VolW'(10);
    ones      = ones_w[vosd_pkg::GlyphW-1:0];

    cfg_d.fill = fill_prod[vosd_pkg::FillShift +: 8];
    if (vol >= vosd_pkg::VolW'(vosd_pkg::VolMax)) begin
      cfg_d.glyph4     = vosd_pkg::GlyphOne;
      cfg_d.glyph5     = vosd_pkg::GlyphZero;
      cfg_d.glyph6     = vosd_pkg::GlyphZero;
      cfg_d.text_left  = 8'(vosd_pkg::Left7);
      cfg_d.text_right = 8'(vosd_pkg::Right7);
    end else if (vol >= vosd_pkg::VolW'(10)) begin
      cfg_d.glyph4     = tens;
      cfg_d.glyph5     = ones;
      cfg_d.glyph6     = vosd_pkg::GlyphBlank;
      cfg_d.text_left  = 8'(vosd_pkg::Left6);
      cfg_d.text_right = 8'(vosd_pkg::Right6);
    end else begin
      cfg_d.glyph4     = ones;
      cfg_d.glyph5     = vosd_pkg::GlyphBlank;
      cfg_d.glyph6     = vosd_pkg::GlyphBlank;
      cfg_d.text_left  = 8'(vosd_pkg::Left5);
      cfg_d.text_right = 8'(vosd_pkg::Right5);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill       <= '0;
      cfg_q.glyph4     <= vosd_pkg::GlyphZero;
      cfg_q.glyph5     <= vosd_pkg::GlyphBlank;
      cfg_q.glyph6     <= vosd_pkg::GlyphBlank;
      cfg_q.text_left  <= 8'(vosd_pkg::Left5);
      cfg_q.text_right <= 8'(vosd_pkg::Right5);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/vosd_pixel.sv
// pixel path: input register, panel text and bar shading, result register
module vosd_pixel #(
  parameter int FrameWidth  = vosd_pkg::FrameWidthDef,
  parameter int FrameHeight = vosd_pkg::FrameHeightDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_i,
  input  logic [vosd_pkg::CoordW-1:0] pixel_x_i,
  input  logic [vosd_pkg::CoordW-1:0] pixel_y_i,
  input  logic [vosd_pkg::ColorW-1:0] background_pixel_i,
  input  vosd_pkg::cfg_t              cfg_i,
  output logic                        valid_o,
  output logic [vosd_pkg::ColorW-1:0] overlay_pixel_o
);

  localparam int FrameMax = (FrameWidth > FrameHeight) ? FrameWidth : FrameHeight;
  localparam int ExtW     = (($clog2(FrameMax) > vosd_pkg::CoordW) ?
                             $clog2(FrameMax) : vosd_pkg::CoordW) + 1;
  localparam int PanelX   = (FrameWidth - vosd_pkg::PanelW) / 2;
  localparam int PanelY   = (FrameHeight - vosd_pkg::PanelH) / 2;

  logic                        in_valid_q, out_valid_q;
  logic [vosd_pkg::CoordW-1:0] x_q, y_q;
  logic [vosd_pkg::ColorW-1:0] bg_q, pix_d, pix_q;

  logic [ExtW-1:0]              x_ext, y_ext, rx_w, ry_w;
  logic                         in_panel;
  logic [vosd_pkg::RelXW-1:0]   rx, dx_w, bx_w;
  logic [vosd_pkg::RelYW-1:0]   ry, dy_w;
  logic [7:0]                   dx, inx_w, bx;
  logic [2:0]                   pos, col, row;
  logic [4:0]                   inx;
  logic [vosd_pkg::GlyphW-1:0]  glyph;
  logic [6:0]                   bits;
  logic                         text_on, in_bar;

  always_comb begin
    x_ext = ExtW'(x_q);
    y_ext = ExtW'(y_q);
    in_panel = (x_ext >= ExtW'(PanelX)) && (x_ext < ExtW'(PanelX + vosd_pkg::PanelW)) &&
               (y_ext >= ExtW'(PanelY)) && (y_ext < ExtW'(PanelY + vosd_pkg::PanelH));
    rx_w = x_ext - ExtW'(PanelX);
    ry_w = y_ext - ExtW'(PanelY);
    rx   = rx_w[vosd_pkg::RelXW-1:0];
    ry   = ry_w[vosd_pkg::RelYW-1:0];

    // text: character slot by threshold compares, then cell within the slot
    dx_w = rx - vosd_pkg::RelXW'(cfg_i.text_left);
    dx   = dx_w[7:0];
    pos  = '0;
    for (int k = 1; k < 7; k++) begin
      pos = pos + 3'(dx >= 8'(k * vosd_pkg::Pitch));
    end
    inx_w = dx - 8'(pos) * 8'(vosd_pkg::Pitch);
    inx   = inx_w[4:0];
    col   = (inx < 5'(5 * vosd_pkg::Scale)) ? inx[4:2] : 3'd0;
    dy_w  = ry - vosd_pkg::RelYW'(vosd_pkg::TextTop);
    row   = dy_w[4:2];

    unique case (pos)
      3'd0:    glyph = vosd_pkg::GlyphV;
      3'd1:    glyph = vosd_pkg::GlyphO;
      3'd2:    glyph = vosd_pkg::GlyphL;
      3'd3:    glyph = vosd_pkg::GlyphBlank;
      3'd4:    glyph = cfg_i.glyph4;
      3'd5:    glyph = cfg_i.glyph5;
      3'd6:    glyph = cfg_i.glyph6;
      default: glyph = vosd_pkg::GlyphBlank;
    endcase
    bits = vosd_pkg::FontCols[glyph][col];

    text_on = (ry >= vosd_pkg::RelYW'(vosd_pkg::TextTop)) &&
              (ry <  vosd_pkg::RelYW'(vosd_pkg::TextTop + 7 * vosd_pkg::Scale)) &&
              (rx >= vosd_pkg::RelXW'(cfg_i.text_left)) &&
              (rx <  vosd_pkg::RelXW'(cfg_i.text_right)) &&
              (inx < 5'(5 * vosd_pkg::Scale)) && bits[row];

    // bar
    in_bar = (rx >= vosd_pkg::RelXW'(vosd_pkg::BarX)) &&
             (rx <  vosd_pkg::RelXW'(vosd_pkg::BarX + vosd_pkg::BarW)) &&
             (ry >= vosd_pkg::RelYW'(vosd_pkg::BarY)) &&
             (ry <  vosd_pkg::RelYW'(vosd_pkg::BarY + vosd_pkg::BarH));
    bx_w = rx - vosd_pkg::RelXW'(vosd_pkg::BarX);
    bx   = bx_w[7:0];

    priority if (!in_panel) begin
      pix_d = bg_q;
    end else if (in_bar) begin
      pix_d = (bx < cfg_i.fill) ? vosd_pkg::ColorWhite : vosd_pkg::ColorTrack;
    end else if (text_on) begin
      pix_d = vosd_pkg::ColorWhite;
    end else begin
      pix_d = vosd_pkg::ColorBlack;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= req_i;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      x_q  <= pixel_x_i;
      y_q  <= pixel_y_i;
      bg_q <= background_pixel_i;
    end
    if (in_valid_q) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o         = out_valid_q;
  assign overlay_pixel_o = pix_q;

endmodule

### rtl/volume_osd_pixel_overlay.sv
// volume osd pixel overlay top level
// a request is taken into the input register, and its result comes out of the result register with valid_o
// throughput: one pixel per clock, the pixel path is a two register pipeline
// busy stays low, results come out one cycle each with valid_o
// reset clears the pipeline valids and sets the volume to zero
module volume_osd_pixel_overlay #(
  parameter int FrameWidth  = vosd_pkg::FrameWidthDef,
  parameter int FrameHeight = vosd_pkg::FrameHeightDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [vosd_pkg::CoordW-1:0] pixel_x_i,
  input  logic [vosd_pkg::CoordW-1:0] pixel_y_i,
  input  logic [vosd_pkg::ColorW-1:0] background_pixel_i,
  input  logic                        cfg_we_i,
  input  logic [vosd_pkg::VolW-1:0]   cfg_wdata_i,
  output logic                        valid_o,
  output logic [vosd_pkg::ColorW-1:0] overlay_pixel_o
);

  localparam int PanelX = (FrameWidth - vosd_pkg::PanelW) / 2;
  localparam int PanelY = (FrameHeight - vosd_pkg::PanelH) / 2;

  vosd_pkg::cfg_t cfg;
  logic           req;

  assign busy = 1'b0;
  assign req  = start && !busy;

  vosd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  vosd_pixel #(
    .FrameWidth  (FrameWidth),
    .FrameHeight (FrameHeight)
  ) u_pixel (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_i              (req),
    .pixel_x_i          (pixel_x_i),
    .pixel_y_i          (pixel_y_i),
    .background_pixel_i (background_pixel_i),
    .cfg_i              (cfg),
    .valid_o            (valid_o),
    .overlay_pixel_o    (overlay_pixel_o)
  );

  // every request gives exactly one result, through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && $past(rst_ni, 2)) |-> (valid_o == $past(req, 2)))
    else $error("result strobe does not follow request");

  // pixels outside the panel pass the background through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (int'($past(pixel_x_i, 2)) < PanelX ||
                 int'($past(pixel_x_i, 2)) >= PanelX + vosd_pkg::PanelW ||
                 int'($past(pixel_y_i, 2)) < PanelY ||
                 int'($past(pixel_y_i, 2)) >= PanelY + vosd_pkg::PanelH))
    |-> (overlay_pixel_o == $past(background_pixel_i, 2)))
    else $error("background not passed outside panel");

  // a volume write above range saturates to a full bar
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_wdata_i >= vosd_pkg::VolW'(vosd_pkg::VolMax))
    |=> (cfg.fill == 8'(vosd_pkg::BarW)))
    else $error("volume write did not saturate");

endmodule
